[src/rc4x_pkg.sv]
// Shared constants and interface types for the keyed RC4-style stream core.
`timescale 1ns / 1ps

package rc4x_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned KeyIdxW  = $clog2(KeyW);
  localparam int unsigned TableLen = 1 << ByteW;

  localparam logic [ByteW-1:0] LastIdx = ByteW'(TableLen - 1);

  // one write and one read on the permutation RAM per cycle
  typedef struct packed {
    logic             we;
    logic [ByteW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [ByteW-1:0] raddr;
  } ram_req_t;

  // sequencer status towards the handshake logic
  typedef struct packed {
    logic             idle;
    logic             done;
    logic [ByteW-1:0] ks;
  } seq_sts_t;

endpackage

[src/rc4x_perm_ram.sv]
// Permutation table: 256 x 8 RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module rc4x_perm_ram
  import rc4x_pkg::*;
(
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem [TableLen];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[src/rc4x_seq.sv]
// Sequencer: table fill, key schedule and keystream steps over the shared RAM.
`timescale 1ns / 1ps

module rc4x_seq
  import rc4x_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             restart_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [ByteW-1:0] rdata_i,
  output ram_req_t         req_o,
  output seq_sts_t         sts_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FILL = 6'b000010,
    ST_RD_I = 6'b000100,
    ST_RD_J = 6'b001000,
    ST_WR_I = 6'b010000,
    ST_WR_J = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic             sched_q, sched_d;
  logic [ByteW-1:0] i_q, i_d;
  logic [ByteW-1:0] j_q, j_d;
  logic [ByteW-1:0] si_q, si_d;
  logic [ByteW-1:0] sj_q, sj_d;
  logic [ByteW-1:0] k_q, k_d;
  logic [ByteW-1:0] i_inc;
  logic [ByteW-1:0] j_new;
  logic [ByteW-1:0] k_sum;
  logic             kbit;

  assign i_inc = i_q + ByteW'(1);
  assign kbit  = key_i[i_q[KeyIdxW-1:0]];
  // adder for the new j during RD_J; the keystream address in WR_I comes from k_sum
  assign j_new = j_q + rdata_i + {{(ByteW-1){1'b0}}, (sched_q & kbit)};
  assign k_sum = si_q + rdata_i;

  always_comb begin
    state_d   = state_q;
    sched_d   = sched_q;
    i_d       = i_q;
    j_d       = j_q;
    si_d      = si_q;
    sj_d      = sj_q;
    k_d       = k_q;
    req_o     = '0;
    sts_o     = '0;
    sts_o.idle = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (restart_i) begin
            i_d     = '0;
            j_d     = '0;
            sched_d = 1'b1;
            state_d = ST_FILL;
          end else begin
            sched_d = 1'b0;
            state_d = ST_RD_I;
          end
        end
      end
      ST_FILL: begin
        // identity table, i doubles as the sweep counter and wraps to zero
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = i_q;
        i_d         = i_inc;
        if (i_q == LastIdx) begin
          state_d = ST_RD_I;
        end
      end
      ST_RD_I: begin
        if (sched_q) begin
          req_o.raddr = i_q;
        end else begin
          req_o.raddr = i_inc;
          i_d         = i_inc;
        end
        state_d = ST_RD_J;
      end
      ST_RD_J: begin
        si_d        = rdata_i;
        j_d         = j_new;
        req_o.raddr = j_new;
        state_d     = ST_WR_I;
      end
      ST_WR_I: begin
        sj_d        = rdata_i;
        k_d         = k_sum;
        req_o.we    = 1'b1;
        req_o.waddr = i_q;
        req_o.wdata = rdata_i;
        // read sees the table before the swap; fix up in WR_J
        req_o.raddr = k_sum;
        state_d     = ST_WR_J;
      end
      ST_WR_J: begin
        req_o.we    = 1'b1;
        req_o.waddr = j_q;
        req_o.wdata = si_q;
        if (sched_q) begin
          i_d     = i_inc;
          state_d = ST_RD_I;
          if (i_q == LastIdx) begin
            sched_d = 1'b0;
          end
        end else begin
          sts_o.done = 1'b1;
          priority if (k_q == i_q) begin
            sts_o.ks = sj_q;
          end else if (k_q == j_q) begin
            sts_o.ks = si_q;
          end else begin
            sts_o.ks = rdata_i;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sched_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    sj_q <= sj_d;
    k_q  <= k_d;
  end

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_sched_ends_on_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sched_q) |-> (i_q == '0) && ($past(state_q) == ST_WR_J))
    else $error("key schedule left before index wrapped");

  a_fill_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> req_o.we && (req_o.waddr == req_o.wdata))
    else $error("fill sweep writes non-identity entry");

  a_fill_into_sched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> sched_q)
    else $error("fill sweep outside a restart");

endmodule

[src/keyed_rc4_stream_xor_core.sv]
// Top level: keyed RC4-style stream XOR core with valid/ready channels and key register.
//
// Usage:
//   Write the 64-bit key with cfg_we_i / cfg_wdata_i while the core is idle.
//   Each input word (data_byte_i, restart_i) yields one output word:
//   out_byte_o = data_byte_i ^ key_byte_o.
//   A word with restart_i set first fills all 256 entries of the permutation
//   table with the identity and runs the keyed schedule (256 steps, each
//   through RD_I, RD_J, WR_I and WR_J), then takes one keystream step.
//   A plain word passes through RD_I, RD_J, WR_I and WR_J; the result is then
//   registered and raises out_valid_o. A restart word runs the fill and the
//   schedule first. A new word is accepted only once the sequencer is idle
//   again. The pace is set by the single RAM port pair: two reads and two
//   writes per swap, the keystream read folded into the swap writes.
//   Reset clears the indices and the key; the table holds nothing usable
//   until the first restart word.
//   If the receiver stalls, a finished word waits in the output register and
//   one more word can be taken and finished into a holding stage; then
//   in_ready_o drops until the held word moves into the output register.
`timescale 1ns / 1ps

module keyed_rc4_stream_xor_core
  import rc4x_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [KeyW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic [ByteW-1:0] key_byte_o
);

  logic [KeyW-1:0]  key_q;
  logic [ByteW-1:0] data_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [ByteW-1:0] key_byte_q;
  logic             pend_valid_q;
  logic [ByteW-1:0] pend_byte_q;
  logic [ByteW-1:0] pend_key_q;
  logic             in_fire;
  logic             out_fire;
  logic             out_free;
  ram_req_t         ram_req;
  logic [ByteW-1:0] ram_rdata;
  seq_sts_t         sts;

  assign in_ready_o = sts.idle && !pend_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || out_ready_i;

  rc4x_perm_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  rc4x_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .restart_i (restart_i),
    .key_i     (key_q),
    .rdata_i   (ram_rdata),
    .req_o     (ram_req),
    .sts_o     (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_wdata_i;
      end
      if (sts.done) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        // advance the held word, or drop valid
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= data_byte_i;
    end
    if (sts.done) begin
      if (out_free) begin
        out_byte_q <= data_q ^ sts.ks;
        key_byte_q <= sts.ks;
      end else begin
        pend_byte_q <= data_q ^ sts.ks;
        pend_key_q  <= sts.ks;
      end
    end else if (out_fire && pend_valid_q) begin
      out_byte_q <= pend_byte_q;
      key_byte_q <= pend_key_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign key_byte_o  = key_byte_q;

  a_pend_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("holding stage full with output register empty");

  a_pend_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("holding stage loaded while output was free");

  a_no_done_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> !pend_valid_q)
    else $error("word finished with both output stages full");

endmodule
